// File: rtl/core/msb_first_bit_packer_assert.svh
// assertion macros shared by the packer modules
`ifndef MSB_FIRST_BIT_PACKER_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mbp_pkg.sv
package mbp_pkg;

  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 6;
  localparam int FIELD_W  = 32;
  localparam int OFFSET_W = 16;
  localparam int BYTE_W   = 8;

  localparam int DEF_STORE_BYTES = 32;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  // control from the sequencer to the byte store
  typedef struct packed {
    logic clear;
    logic bit_en;
    logic bit_val;
    logic pad;
    logic rd_en;
  } store_ctl_t;

endpackage

// File: rtl/core/mbp_if.sv
interface mbp_field_if import mbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [COUNT_W-1:0]  bit_count;
  logic [FIELD_W-1:0]  field_value;
  logic [OFFSET_W-1:0] length_offset;

  modport source (output valid, mode, bit_count, field_value, length_offset, input ready);
  modport sink   (input valid, mode, bit_count, field_value, length_offset, output ready);
endinterface

interface mbp_byte_if import mbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;
  logic              bits_dropped;

  modport source (output valid, out_byte, last_byte, bits_dropped, input ready);
  modport sink   (input valid, out_byte, last_byte, bits_dropped, output ready);
endinterface

// File: rtl/core/mbp_shifter.sv
module mbp_shifter import mbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [FIELD_W-1:0] field_value,
  input  logic [COUNT_W-1:0] bit_count,
  output logic               bit_en,
  output logic               bit_val,
  output logic               done
);

  localparam int STEP_W = $clog2(FIELD_W);

  logic [FIELD_W-1:0] sreg;
  logic [COUNT_W-1:0] n;
  logic [STEP_W-1:0]  step;
  logic               busy;

  // step k presents field bit (31 - k); it is appended once it lies below n
  assign bit_val = sreg[FIELD_W-1];
  assign bit_en  = busy && ({1'b0, ~step} < n);
  assign done    = busy && (step == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sreg <= field_value;
      n    <= (bit_count > COUNT_W'(FIELD_W)) ? COUNT_W'(FIELD_W) : bit_count;
    end else if (busy) begin
      sreg <= {sreg[FIELD_W-2:0], 1'b0};
    end
  end

endmodule

// File: rtl/core/mbp_store.sv
module mbp_store import mbp_pkg::*; #(
  parameter int STORE_BYTES = DEF_STORE_BYTES,
  localparam int CAP_BITS = STORE_BYTES * BYTE_W,
  localparam int FILL_W   = $clog2(CAP_BITS + 1),
  localparam int ADDR_W   = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  store_ctl_t        ctl,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [FILL_W-1:0] fill,
  output logic              overflow,
  output logic [BYTE_W-1:0] rd_data
);

  `include "msb_first_bit_packer_assert.svh"

  logic [BYTE_W-1:0] mem [STORE_BYTES];
  logic [BYTE_W-1:0] cur;
  logic [2:0]        part;
  logic              full;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] cur_shift;
  logic [BYTE_W-1:0] cur_pad;

  assign part      = fill[2:0];
  assign full      = (fill >= FILL_W'(CAP_BITS));
  assign wr_addr   = ADDR_W'(fill >> 3);
  assign cur_shift = {cur[BYTE_W-2:0], ctl.bit_val};
  // left-justify the partial byte, zeros in the unused low bits
  assign cur_pad   = BYTE_W'(cur << (4'd8 - {1'b0, part}));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      overflow <= 1'b0;
    end else if (ctl.clear) begin
      fill     <= '0;
      overflow <= 1'b0;
    end else if (ctl.bit_en) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.bit_en && !full) begin
      cur <= cur_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.bit_en && !full && (part == 3'd7)) begin
      mem[wr_addr] <= cur_shift;
    end else if (ctl.pad && (part != 3'd0)) begin
      mem[wr_addr] <= cur_pad;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  `MBP_ASSERT_NOW(a_fill_in_range, 1'b1, fill <= FILL_W'(CAP_BITS), "bit fill beyond capacity")
  `MBP_ASSERT_NOW(a_ovf_only_when_full, $rose(overflow), fill == FILL_W'(CAP_BITS), "overflow below capacity")

endmodule

// File: rtl/core/msb_first_bit_packer.sv
// clear empties the store when the item is taken; append: after the item is taken the field
//   shifter steps through every field bit position, one bit each, whatever bit_count is
// flush: 2 header bytes, then for each data byte a store read and an output load;
//   the header and data loads wait while the output side stalls
// reset (rst, synchronous): empties the store and drops any pending output item;
//   store memory contents are not cleared, the bit fill count gates every read
module msb_first_bit_packer import mbp_pkg::*; #(
  parameter int STORE_BYTES = DEF_STORE_BYTES
) (
  input logic       clk,
  input logic       rst,
  mbp_field_if.sink field_ch,
  mbp_byte_if.source byte_ch
);

  `include "msb_first_bit_packer_assert.svh"

  localparam int CAP_BITS = STORE_BYTES * BYTE_W;
  localparam int FILL_W   = $clog2(CAP_BITS + 1);
  localparam int ADDR_W   = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int NB_W     = $clog2(STORE_BYTES + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SHIFT  = 6'b000010,
    S_HDR_HI = 6'b000100,
    S_HDR_LO = 6'b001000,
    S_RD     = 6'b010000,
    S_DATA   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic accept;
  logic sh_load, sh_bit_en, sh_bit_val, sh_done;

  store_ctl_t        ctl;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_up;
  logic [NB_W-1:0]   nb_now;
  logic              overflow;
  logic [BYTE_W-1:0] rd_data;

  // flush context, captured when the flush item is taken
  logic [OFFSET_W-1:0] hdr;
  logic [NB_W-1:0]     nb;
  logic                drop;
  logic [ADDR_W-1:0]   idx;
  logic                last_data;

  // output register, parts the store from the consumer
  logic              ov;
  logic [BYTE_W-1:0] ob;
  logic              ol, od;
  logic              can_load;
  logic              out_load;
  logic [BYTE_W-1:0] load_byte;
  logic              load_last, load_drop;

  assign field_ch.ready = (state == S_IDLE);
  assign accept         = field_ch.valid && field_ch.ready;

  assign byte_ch.valid        = ov;
  assign byte_ch.out_byte     = ob;
  assign byte_ch.last_byte    = ol;
  assign byte_ch.bits_dropped = od;

  assign can_load = !ov || byte_ch.ready;

  // bytes held, rounded up; fill + 7 always fits in the fill width
  assign fill_up   = fill + FILL_W'(7);
  assign nb_now    = NB_W'(fill_up >> 3);
  assign last_data = ((NB_W'(idx) + NB_W'(1)) == nb);

  mbp_shifter u_shifter (
    .clk         (clk),
    .rst         (rst),
    .load        (sh_load),
    .field_value (field_ch.field_value),
    .bit_count   (field_ch.bit_count),
    .bit_en      (sh_bit_en),
    .bit_val     (sh_bit_val),
    .done        (sh_done)
  );

  mbp_store #(.STORE_BYTES(STORE_BYTES)) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_addr  (idx),
    .fill     (fill),
    .overflow (overflow),
    .rd_data  (rd_data)
  );

  // sequencer
  always_comb begin
    state_next  = state;
    sh_load     = 1'b0;
    ctl.clear   = 1'b0;
    ctl.bit_en  = sh_bit_en;
    ctl.bit_val = sh_bit_val;
    ctl.pad     = 1'b0;
    ctl.rd_en   = 1'b0;
    out_load    = 1'b0;
    load_byte   = hdr[OFFSET_W-1:BYTE_W];
    load_last   = 1'b0;
    load_drop   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (field_ch.mode)
            MODE_CLEAR: begin
              ctl.clear = 1'b1;
            end
            MODE_APPEND: begin
              sh_load    = 1'b1;
              state_next = S_SHIFT;
            end
            MODE_FLUSH: begin
              // write out the partial byte and empty the store at once;
              // the memory keeps its bytes for the read-out below
              ctl.pad    = 1'b1;
              ctl.clear  = 1'b1;
              state_next = S_HDR_HI;
            end
            default: begin
              // unused mode, item is dropped without results
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (sh_done) begin
          state_next = S_IDLE;
        end
      end
      S_HDR_HI: begin
        if (can_load) begin
          out_load   = 1'b1;
          state_next = S_HDR_LO;
        end
      end
      S_HDR_LO: begin
        load_byte = hdr[BYTE_W-1:0];
        load_last = (nb == '0);
        load_drop = (nb == '0) && drop;
        if (can_load) begin
          out_load   = 1'b1;
          state_next = (nb == '0) ? S_IDLE : S_RD;
        end
      end
      S_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_DATA;
      end
      S_DATA: begin
        load_byte = rd_data;
        load_last = last_data;
        load_drop = last_data && drop;
        if (can_load) begin
          out_load   = 1'b1;
          state_next = last_data ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (field_ch.mode == MODE_FLUSH)) begin
      hdr  <= field_ch.length_offset + OFFSET_W'(nb_now);
      nb   <= nb_now;
      drop <= overflow;
      idx  <= '0;
    end else if ((state == S_DATA) && can_load) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_load) begin
      ov <= 1'b1;
    end else if (byte_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ob <= load_byte;
      ol <= load_last;
      od <= load_drop;
    end
  end

  `MBP_ASSERT_NOW(a_data_has_bytes, state == S_DATA, nb != '0, "data read-out with no bytes")
  `MBP_ASSERT_NOW(a_shift_in_state, sh_done, state == S_SHIFT, "shifter ran outside append")

endmodule
